>>> rtl/core/prld_pkg.sv
`default_nettype none

package prld_pkg;

  localparam logic [7:0]  LITERAL_MARK  = 8'd253;
  localparam logic [15:0] FRAME_PIXELS_RESET = 16'd4096;

  // End status codes carried on the final result of a frame.
  localparam logic [1:0] ST_FILLED  = 2'd0;
  localparam logic [1:0] ST_BETWEEN = 2'd1;
  localparam logic [1:0] ST_MID     = 2'd2;

  typedef enum logic [3:0] {
    PH_HEADER   = 4'b0001,
    PH_LITCOUNT = 4'b0010,
    PH_COLOR_LO = 4'b0100,
    PH_COLOR_HI = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       stream_last;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_color;
    logic [7:0]  repeat_count;
    logic        frame_end;
    logic [1:0]  end_status;
  } out_item_t;

  typedef struct packed {
    phase_e      parse_phase;
    logic        is_literal;
    logic [7:0]  run_length;
    logic [7:0]  literal_left;
    logic [7:0]  color_low;
    logic [15:0] pixels_done;
    logic        frame_full;
  } dec_state_t;

  localparam dec_state_t DEC_STATE_RESET = '{
    parse_phase:  PH_HEADER,
    is_literal:   1'b0,
    run_length:   8'd0,
    literal_left: 8'd0,
    color_low:    8'd0,
    pixels_done:  16'd0,
    frame_full:   1'b0
  };

endpackage

`default_nettype wire

>>> rtl/core/pixel_rle_literal_decoder.sv
// Run-length decoder for 16-bit pixel streams with literal sections.
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one compressed byte
// per transaction; stream_last marks the final byte of a stream.
// Output channel (out_valid_o/out_ready_i/out_data_o) gives one run
// descriptor per completed colour with a nonzero repeat count, or a status-only result at stream end.
// Configuration channel (cfg_valid_i/cfg_ready_o/cfg_data_i) writes the frame
// size in pixels; it is always ready and should be written only while idle.
// A byte is held in an input register and decoded combationally; any result
// it gives is written into the result register when the byte moves on.
// Throughput is one byte per cycle while the receiver does not stall, set by
// the single decode step between the input register and the result register.
// When the receiver stalls, the result register holds and at most one more byte
// is taken into the input register; after that the input channel stalls too.
// Reset empties both registers, returns the parser to the entry header and
// sets the frame size to 4096 pixels.
`default_nettype none

module pixel_rle_literal_decoder
  import prld_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_item_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);

  logic        s1_valid_q;
  in_item_t    s1_item_q;
  logic        out_valid_q;
  out_item_t   out_item_q;
  logic [15:0] frame_pixels_q;
  dec_state_t  state_q;
  dec_state_t  state_d;
  logic        res_valid;
  out_item_t   res_item;
  logic        advance;

  assign advance     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

  prld_step u_step (
    .state_i       (state_q),
    .item_i        (s1_item_q),
    .frame_pixels_i(frame_pixels_q),
    .state_o       (state_d),
    .res_valid_o   (res_valid),
    .res_o         (res_item)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      frame_pixels_q <= FRAME_PIXELS_RESET;
      state_q        <= DEC_STATE_RESET;
    end else begin
      if (in_valid_i && in_ready_o) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= res_valid;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        frame_pixels_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_data_i;
    end
    if (advance && res_valid) begin
      out_item_q <= res_item;
    end
  end

  // A result that does not close the frame always carries pixels.
  a_mid_result_has_pixels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.frame_end |->
      out_data_o.repeat_count != 8'd0 && out_data_o.end_status == ST_FILLED)
    else $error("non-final result without pixels or with a status");

  // A stream that ends inside an entry reports no colour.
  a_mid_entry_status_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.end_status == ST_MID |->
      out_data_o.repeat_count == 8'd0 && out_data_o.pixel_color == 16'd0)
    else $error("mid-entry status carries a colour");

  // The input register is only overwritten when its byte moves on.
  a_no_input_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && s1_valid_q |-> advance)
    else $error("input register overwritten before decode");

  // A stalled result is not replaced.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_item_q))
    else $error("pending result lost while stalled");

endmodule

`default_nettype wire

>>> rtl/core/prld_step.sv
`default_nettype none

module prld_step
  import prld_pkg::*;
(
  input  dec_state_t  state_i,
  input  in_item_t    item_i,
  input  logic [15:0] frame_pixels_i,
  output dec_state_t  state_o,
  output logic        res_valid_o,
  output out_item_t   res_o
);

  logic [7:0]  rep_raw;
  logic [7:0]  rep;
  logic [15:0] room;
  logic [15:0] done_sum;
  logic        filled;
  logic [7:0]  lit_next;
  phase_e      phase_next;

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o       = '{pixel_color: 16'd0, repeat_count: 8'd0,
                    frame_end: 1'b1, end_status: ST_MID};

    rep_raw    = state_i.is_literal ? 8'd1 : state_i.run_length;
    room       = (state_i.pixels_done >= frame_pixels_i) ? 16'd0
                 : frame_pixels_i - state_i.pixels_done;
    rep        = ({8'd0, rep_raw} > room) ? room[7:0] : rep_raw;
    done_sum   = state_i.pixels_done + {8'd0, rep};
    filled     = done_sum >= frame_pixels_i;
    lit_next   = state_i.literal_left - 8'd1;
    phase_next = PH_HEADER;
    if (state_i.is_literal && lit_next != 8'd0) begin
      phase_next = PH_COLOR_LO;
    end

    if (state_i.frame_full) begin
      // Bytes after a filled frame are dropped up to the end of the stream.
      if (item_i.stream_last) begin
        state_o = DEC_STATE_RESET;
      end
    end else begin
      case (state_i.parse_phase)
        PH_COLOR_LO: begin
          state_o.color_low   = item_i.code_byte;
          state_o.parse_phase = PH_COLOR_HI;
          if (item_i.stream_last) begin
            res_valid_o = 1'b1;
            state_o     = DEC_STATE_RESET;
          end
        end
        PH_COLOR_HI: begin
          state_o.pixels_done = done_sum;
          state_o.parse_phase = phase_next;
          if (state_i.is_literal) begin
            state_o.literal_left = lit_next;
          end
          res_o.pixel_color  = {item_i.code_byte, state_i.color_low};
          res_o.repeat_count = rep;
          if (filled) begin
            res_valid_o      = 1'b1;
            res_o.end_status = ST_FILLED;
            if (item_i.stream_last) begin
              state_o = DEC_STATE_RESET;
            end else begin
              state_o.frame_full = 1'b1;
            end
          end else if (item_i.stream_last) begin
            res_valid_o = 1'b1;
            if (phase_next == PH_HEADER) begin
              res_o.end_status = ST_BETWEEN;
            end else begin
              res_o.pixel_color  = 16'd0;
              res_o.repeat_count = 8'd0;
              res_o.end_status   = ST_MID;
            end
            state_o = DEC_STATE_RESET;
          end else if (rep != 8'd0) begin
            res_valid_o      = 1'b1;
            res_o.frame_end  = 1'b0;
            res_o.end_status = ST_FILLED;
          end
        end
        PH_LITCOUNT: begin
          state_o.literal_left = item_i.code_byte;
          state_o.parse_phase  = (item_i.code_byte != 8'd0) ? PH_COLOR_LO : PH_HEADER;
          if (item_i.stream_last) begin
            res_valid_o      = 1'b1;
            res_o.end_status = (item_i.code_byte != 8'd0) ? ST_MID : ST_BETWEEN;
            state_o          = DEC_STATE_RESET;
          end
        end
        default: begin
          // Entry header; unused phase codes are read the same way.
          if (item_i.code_byte == LITERAL_MARK) begin
            state_o.is_literal  = 1'b1;
            state_o.parse_phase = PH_LITCOUNT;
          end else begin
            state_o.is_literal  = 1'b0;
            state_o.run_length  = item_i.code_byte;
            state_o.parse_phase = PH_COLOR_LO;
          end
          if (item_i.stream_last) begin
            res_valid_o = 1'b1;
            state_o     = DEC_STATE_RESET;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire
